>>> hdl/pclm_pkg.sv
// Types and constants shared by the pooled circular list manager.
package pclm_pkg;
    localparam int POOL_SLOTS = 64;
    localparam int DATA_BITS  = 32;
    localparam int SLOT_BITS  = $clog2(POOL_SLOTS);
    localparam int CNT_BITS   = $clog2(POOL_SLOTS + 1);

    typedef enum logic [2:0] {
        CMD_APPEND  = 3'd0,
        CMD_PREPEND = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_ROT_FWD = 3'd4,
        CMD_ROT_BCK = 3'd5,
        CMD_FIND    = 3'd6,
        CMD_READ    = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_UNUSED   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  node_in;
        logic [31:0] data_in;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  node_out;
        logic [31:0] data_out;
        logic [6:0]  list_size;
        logic [5:0]  head_node;
    } t_out_word;
endpackage

>>> hdl/pooled_circular_list_manager.sv
// Top level: pooled circular doubly linked list manager with LIFO free list.
// Usage:
//   Input channel i_valid/o_ready carries one command word (t_in_word);
//   output channel o_valid/i_ready returns exactly one result word per command.
//   Commands run on a small sequencer around one read port per link store:
//   each step reads one slot's links/data through a registered read and
//   writes the links in a later state. Find walks the list from the head,
//   one slot per read, passing over up to list size slots before the result.
//   One command in flight at a time; o_ready is high only when idle and no
//   result word is waiting.
//   After reset (i_rst_n low, synchronous) a clearing pass sets each slot's
//   next link to the following slot, wrapping to 0; no command is taken until it ends.
//   Slot data and prev links are not cleared.
//   The result is held in an output register until i_ready takes it; the
//   next command is taken only after that.
module pooled_circular_list_manager (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pclm_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output pclm_pkg::t_out_word o_data
);
    import pclm_pkg::*;

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_EXEC  = 10'b0000001000,
        S_RD2   = 10'b0000010000,
        S_LINK  = 10'b0000100000,
        S_RD3   = 10'b0001000000,
        S_FIX   = 10'b0010000000,
        S_WALK  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    logic [SLOT_BITS-1:0] mem_next [POOL_SLOTS];
    logic [SLOT_BITS-1:0] mem_prev [POOL_SLOTS];
    logic [DATA_BITS-1:0] mem_data [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_used;

    t_state               r_state;
    logic [SLOT_BITS-1:0] r_free, r_head;
    logic [CNT_BITS-1:0]  r_count, r_walk;
    logic [SLOT_BITS-1:0] r_addr;
    logic [SLOT_BITS-1:0] r_rd_next, r_rd_prev;
    logic [DATA_BITS-1:0] r_rd_data;
    logic [2:0]           r_cmd;
    logic [SLOT_BITS-1:0] r_t, r_s, r_n, r_p;
    logic [DATA_BITS-1:0] r_d;
    logic                 r_ovalid;
    t_out_word            r_out;
    logic [SLOT_BITS-1:0] r_init;

    logic                 we_next, we_prev, we_data;
    logic [SLOT_BITS-1:0] wa_next, wa_prev, wa_data;
    logic [SLOT_BITS-1:0] wd_next, wd_prev;

    logic full, empty;
    assign full  = (r_count == CNT_BITS'(POOL_SLOTS));
    assign empty = (r_count == '0);

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (we_next) mem_next[wa_next] <= wd_next;
        if (we_prev) mem_prev[wa_prev] <= wd_prev;
        if (we_data) mem_data[wa_data] <= r_d;
        r_rd_next <= mem_next[r_addr];
        r_rd_prev <= mem_prev[r_addr];
        r_rd_data <= mem_data[r_addr];
    end

    // single write per store per cycle; link ops spread over states
    always_comb begin
        we_next = 1'b0; we_prev = 1'b0; we_data = 1'b0;
        wa_next = r_s;  wa_prev = r_s;  wa_data = r_s;
        wd_next = r_s;  wd_prev = r_s;
        if (r_state == S_INIT) begin
            we_next = 1'b1; wa_next = r_init; wd_next = r_init + 1'b1;
        end else if (r_state == S_LINK) begin
            // new node s between t and n
            we_next = 1'b1; wa_next = r_s; wd_next = r_n;
            we_prev = 1'b1; wa_prev = r_s; wd_prev = r_t;
            we_data = 1'b1;
        end else if (r_state == S_FIX) begin
            if (r_cmd == CMD_DELETE) begin
                we_next = 1'b1; wa_next = r_p; wd_next = r_n;
                we_prev = 1'b1; wa_prev = r_n; wd_prev = r_p;
            end else begin
                we_next = 1'b1; wa_next = r_t; wd_next = r_s;
                we_prev = 1'b1; wa_prev = r_n; wd_prev = r_s;
            end
        end else if (r_state == S_OUT && r_cmd == CMD_DELETE && !r_ovalid
                     && r_out.status == ST_OK) begin
            we_next = 1'b1; wa_next = r_t; wd_next = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_used   <= '0;
            r_free   <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_init <= r_init + 1'b1;
                    if (r_init == SLOT_BITS'(POOL_SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_cmd <= i_data.cmd;
                        r_t   <= i_data.node_in;
                        r_d   <= i_data.data_in;
                        r_out <= '0;
                        r_walk <= r_count;
                        r_state <= S_RD;
                        case (t_cmd'(i_data.cmd))
                            CMD_APPEND, CMD_PREPEND, CMD_INSERT: r_addr <= r_free;
                            CMD_ROT_FWD, CMD_ROT_BCK, CMD_FIND:  r_addr <= r_head;
                            default: r_addr <= i_data.node_in;
                        endcase
                    end
                end
                S_RD: r_state <= (r_cmd == CMD_FIND) ? S_WALK : S_EXEC;
                S_EXEC: begin
                    r_state <= S_OUT;
                    case (t_cmd'(r_cmd))
                        CMD_APPEND, CMD_PREPEND: begin
                            if (full) r_out.status <= ST_FULL;
                            else begin
                                r_s <= r_free;
                                r_free <= r_rd_next;
                                r_used[r_free] <= 1'b1;
                                r_count <= r_count + 1'b1;
                                r_out.node_out <= r_free;
                                if (empty) begin
                                    r_head <= r_free;
                                    r_t <= r_free; r_n <= r_free;
                                    r_state <= S_LINK;
                                end else begin
                                    if (r_cmd == CMD_PREPEND) r_head <= r_free;
                                    r_n <= r_head;
                                    r_addr <= r_head;
                                    r_state <= S_RD2;
                                end
                            end
                        end
                        CMD_INSERT: begin
                            if (empty) r_out.status <= ST_EMPTY;
                            else if (!r_used[r_t]) r_out.status <= ST_UNUSED;
                            else if (full) r_out.status <= ST_FULL;
                            else begin
                                r_s <= r_free;
                                r_free <= r_rd_next;
                                r_used[r_free] <= 1'b1;
                                r_count <= r_count + 1'b1;
                                r_out.node_out <= r_free;
                                r_addr <= r_t;
                                r_state <= S_RD2;
                            end
                        end
                        CMD_DELETE: begin
                            if (empty) r_out.status <= ST_EMPTY;
                            else if (!r_used[r_t]) r_out.status <= ST_UNUSED;
                            else begin
                                r_p <= r_rd_prev; r_n <= r_rd_next;
                                r_used[r_t] <= 1'b0;
                                r_count <= r_count - 1'b1;
                                r_out.node_out <= r_t;
                                if (r_count == CNT_BITS'(1)) r_head <= '0;
                                else begin
                                    if (r_head == r_t) r_head <= r_rd_next;
                                    r_state <= S_FIX;
                                end
                            end
                        end
                        CMD_ROT_FWD, CMD_ROT_BCK: begin
                            if (empty) r_out.status <= ST_EMPTY;
                            else if (r_cmd == CMD_ROT_FWD) r_head <= r_rd_next;
                            else r_head <= r_rd_prev;
                        end
                        CMD_FIND: begin
                            r_state <= S_WALK;
                        end
                        default: begin
                            if (!r_used[r_t]) r_out.status <= ST_UNUSED;
                            else begin
                                r_out.node_out <= r_t;
                                r_out.data_out <= r_rd_data;
                            end
                        end
                    endcase
                end
                S_RD2: r_state <= S_RD3;
                S_RD3: begin
                    // append/prepend: prev of head is tail t; insert: next of t
                    if (r_cmd == CMD_INSERT) r_n <= r_rd_next;
                    else r_t <= r_rd_prev;
                    r_state <= S_LINK;
                end
                S_LINK: r_state <= (r_t == r_s) ? S_OUT : S_FIX;
                S_FIX:  r_state <= S_OUT;
                S_WALK: begin
                    if (r_walk == '0) begin
                        r_out.status <= ST_NOTFOUND;
                        r_state <= S_OUT;
                    end else if (r_rd_data == r_d) begin
                        r_out.node_out <= r_addr;
                        r_out.data_out <= r_rd_data;
                        r_state <= S_OUT;
                    end else begin
                        r_walk <= r_walk - 1'b1;
                        r_addr <= r_rd_next;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        if (r_cmd == CMD_DELETE && r_out.status == ST_OK) r_free <= r_t;
                        r_out.list_size <= r_count;
                        r_out.head_node <= r_head;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
